FILE: rtl/core/sdq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register map and internal struct types of the spike delay queue.
// No dependencies; every other file imports this package.
package sdq_pkg;

   localparam int QUEUE_SLOTS = 8;
   localparam int IDX_W       = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
   localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);

   localparam int TIMER_W     = 16;
   localparam int POT_W       = 16;
   localparam int THR_W       = 15;
   localparam int LEVEL_W     = 8;
   localparam int QCNT_W      = 4;

   // remainder unit: dividend is the positive excess over threshold, minus one
   localparam int DIVIDEND_W  = POT_W - 1;
   localparam int STEP_W      = $clog2(DIVIDEND_W);

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int REG_IDX_W   = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_FIRE_THRESHOLD     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_POST_FIRE_REACTION = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FIRE_SPACING       = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TRAVEL_DELAY       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_NO_RETURN_TIME     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_FIRE_LEVEL         = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_IDLE_LEVEL         = 3'd6;

   localparam logic [THR_W-1:0]   RST_FIRE_THRESHOLD     = 15'd256;
   localparam logic [POT_W-1:0]   RST_POST_FIRE_REACTION = 16'hFF00;  // -256
   localparam logic [TIMER_W-1:0] RST_FIRE_SPACING       = 16'd100;
   localparam logic [TIMER_W-1:0] RST_TRAVEL_DELAY       = 16'd100;
   localparam logic [TIMER_W-1:0] RST_NO_RETURN_TIME     = 16'd10;
   localparam logic [LEVEL_W-1:0] RST_FIRE_LEVEL         = 8'd255;
   localparam logic [LEVEL_W-1:0] RST_IDLE_LEVEL         = 8'd0;

   typedef struct packed {
      logic [THR_W-1:0]        fire_threshold;
      logic signed [POT_W-1:0] post_fire_reaction;
      logic [TIMER_W-1:0]      fire_spacing;
      logic [TIMER_W-1:0]      travel_delay;
      logic [TIMER_W-1:0]      no_return_time;
      logic [LEVEL_W-1:0]      fire_level;
      logic [LEVEL_W-1:0]      idle_level;
   } cfg_type;

   // sequencer -> timer queue
   typedef struct packed {
      logic               scan;   // one slot of a latest/first-empty scan
      logic               count;  // one slot of the countdown pass
      logic               write;  // direct slot write
      logic [IDX_W-1:0]   widx;
      logic [TIMER_W-1:0] wval;
   } q_cmd_type;

   // timer queue -> sequencer
   typedef struct packed {
      logic               last;      // current pass step is the final slot
      logic               expired;   // countdown step took a timer to zero
      logic [IDX_W-1:0]   best_idx;
      logic [TIMER_W-1:0] best_val;
      logic [IDX_W-1:0]   empty_idx;
   } q_stat_type;

endpackage

FILE: rtl/core/sdq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the spike delay queue: input item and result item.
// Depends on sdq_pkg.
interface sdq_req_if;
   import sdq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POT_W-1:0] potential_in;
   modport source (output valid, output potential_in, input ready);
   modport sink   (input valid, input potential_in, output ready);
endinterface

interface sdq_rsp_if;
   import sdq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POT_W-1:0] potential_out;
   logic [LEVEL_W-1:0]      dac_level;
   logic [QCNT_W-1:0]       pulses_queued;
   logic                    pulse_started;
   modport source (output valid, output potential_out, output dac_level,
                   output pulses_queued, output pulse_started, input ready);
   modport sink   (input valid, input potential_out, input dac_level,
                   input pulses_queued, input pulse_started, output ready);
endinterface

FILE: rtl/core/sdq_csr.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the spike delay queue.
// Depends on sdq_pkg.
module sdq_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sdq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sdq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sdq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output sdq_pkg::cfg_type               cfg
);
   import sdq_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FIRE_THRESHOLD:     cfg_in.fire_threshold     = pwdata[THR_W-1:0];
            REG_POST_FIRE_REACTION: cfg_in.post_fire_reaction = pwdata[POT_W-1:0];
            REG_FIRE_SPACING:       cfg_in.fire_spacing       = pwdata[TIMER_W-1:0];
            REG_TRAVEL_DELAY:       cfg_in.travel_delay       = pwdata[TIMER_W-1:0];
            REG_NO_RETURN_TIME:     cfg_in.no_return_time     = pwdata[TIMER_W-1:0];
            REG_FIRE_LEVEL:         cfg_in.fire_level         = pwdata[LEVEL_W-1:0];
            REG_IDLE_LEVEL:         cfg_in.idle_level         = pwdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FIRE_THRESHOLD:     prdata = {{(CSR_DATA_W-THR_W){1'b0}}, cfg_ff.fire_threshold};
         REG_POST_FIRE_REACTION: prdata = {{(CSR_DATA_W-POT_W){1'b0}},
                                           cfg_ff.post_fire_reaction};
         REG_FIRE_SPACING:       prdata = {{(CSR_DATA_W-TIMER_W){1'b0}}, cfg_ff.fire_spacing};
         REG_TRAVEL_DELAY:       prdata = {{(CSR_DATA_W-TIMER_W){1'b0}}, cfg_ff.travel_delay};
         REG_NO_RETURN_TIME:     prdata = {{(CSR_DATA_W-TIMER_W){1'b0}}, cfg_ff.no_return_time};
         REG_FIRE_LEVEL:         prdata = {{(CSR_DATA_W-LEVEL_W){1'b0}}, cfg_ff.fire_level};
         REG_IDLE_LEVEL:         prdata = {{(CSR_DATA_W-LEVEL_W){1'b0}}, cfg_ff.idle_level};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fire_threshold     <= RST_FIRE_THRESHOLD;
         cfg_ff.post_fire_reaction <= RST_POST_FIRE_REACTION;
         cfg_ff.fire_spacing       <= RST_FIRE_SPACING;
         cfg_ff.travel_delay       <= RST_TRAVEL_DELAY;
         cfg_ff.no_return_time     <= RST_NO_RETURN_TIME;
         cfg_ff.fire_level         <= RST_FIRE_LEVEL;
         cfg_ff.idle_level         <= RST_IDLE_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/sdq_timer_queue.sv
`timescale 1ns / 1ps
// Pulse timer slots with a single compare/decrement unit stepped one slot per cycle.
// Depends on sdq_pkg.
module sdq_timer_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  sdq_pkg::q_cmd_type   cmd,
   output sdq_pkg::q_stat_type  stat
);
   import sdq_pkg::*;

   logic [TIMER_W-1:0] timers_ff [QUEUE_SLOTS];
   logic [TIMER_W-1:0] timers_in [QUEUE_SLOTS];
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [TIMER_W-1:0] best_val_ff, best_val_in;
   logic [IDX_W-1:0]   empty_idx_ff, empty_idx_in;
   logic               found_ff, found_in;
   logic [TIMER_W-1:0] rd;
   logic               last;
   logic               first;

   assign rd    = timers_ff[idx_ff];
   assign last  = (idx_ff == IDX_W'(QUEUE_SLOTS - 1));
   assign first = (idx_ff == '0);

   always_comb begin
      timers_in = timers_ff;
      if (cmd.write) begin
         timers_in[cmd.widx] = cmd.wval;
      end else if (cmd.count && rd != '0) begin
         timers_in[idx_ff] = rd - TIMER_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan || cmd.count) begin
         idx_in = last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   // latest slot: strict greater-than keeps the lowest index on ties
   always_comb begin
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      empty_idx_in = empty_idx_ff;
      found_in     = found_ff;
      if (cmd.scan) begin
         if (first) begin
            best_idx_in  = '0;
            best_val_in  = rd;
            empty_idx_in = '0;
            found_in     = (rd == '0);
         end else begin
            if (rd > best_val_ff) begin
               best_idx_in = idx_ff;
               best_val_in = rd;
            end
            if (!found_ff && rd == '0) begin
               found_in     = 1'b1;
               empty_idx_in = idx_ff;
            end
         end
      end
   end

   assign stat.last      = last;
   assign stat.expired   = cmd.count && (rd == TIMER_W'(1));
   assign stat.best_idx  = best_idx_ff;
   assign stat.best_val  = best_val_ff;
   assign stat.empty_idx = empty_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         for (int i = 0; i < QUEUE_SLOTS; i++) begin
            timers_ff[i] <= '0;
         end
      end else begin
         idx_ff    <= idx_in;
         timers_ff <= timers_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_val_ff  <= best_val_in;
      empty_idx_ff <= empty_idx_in;
      found_ff     <= found_in;
   end

endmodule

FILE: rtl/core/sdq_rem_unit.sv
`timescale 1ns / 1ps
// Restoring shift-subtract remainder unit, one dividend bit per cycle.
// Depends on sdq_pkg.
module sdq_rem_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sdq_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [sdq_pkg::POT_W-1:0]      divisor,
   output logic                           done,
   output logic [sdq_pkg::POT_W-1:0]      remainder
);
   import sdq_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] x_ff, x_in;
   logic [POT_W-1:0]      m_ff, m_in;
   logic [POT_W-1:0]      rem_ff, rem_in;
   logic [POT_W:0]        shifted;
   logic [POT_W:0]        diff;

   // remainder stays below the divisor, so the shifted value is under twice it
   assign shifted = {rem_ff, x_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, m_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      m_in    = m_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in    = dividend;
         m_in    = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = (shifted >= {1'b0, m_ff}) ? diff[POT_W-1:0] : shifted[POT_W-1:0];
         x_in    = {x_ff[DIVIDEND_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      m_ff   <= m_in;
      rem_ff <= rem_in;
   end

endmodule

FILE: rtl/core/spike_delay_queue.sv
`timescale 1ns / 1ps
// Spike delay queue top level: sequencer, potential datapath and result register.
// Depends on sdq_pkg, sdq_if, sdq_csr, sdq_timer_queue and sdq_rem_unit.
//
// Usage:
//  - req_ch carries one membrane potential per neuron tick; rsp_ch returns one
//    result item per input item (adjusted potential, DAC level, queued pulse
//    count, pulse-start flag), in order.
//  - APB port writes the seven settings; write them only while the block is idle.
//  - Items are processed one at a time. Steps per item: accept, a threshold check,
//    for each pulse scheduled into a free slot a scan over all slots, a write and
//    the following check, a remainder division if the queue is full while the
//    potential is still above threshold, a cancel check plus a scan and a cancel
//    attempt, a countdown pass over all slots and loading the result. The scans
//    and the countdown step through the slots one at a time on the single timer
//    compare/decrement unit.
//  - The result sits in an output register; the next item is accepted while it
//    waits. If the receiver stalls, the following item finishes its work and
//    then holds in the last step until the output register frees.
//  - Reset (synchronous) empties all timer slots, clears the pulse state, sets
//    the DAC level to zero and restores the register defaults.
module spike_delay_queue (
   input  logic                           clock,
   input  logic                           reset,
   sdq_req_if.sink                        req_ch,
   sdq_rsp_if.source                      rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sdq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sdq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sdq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import sdq_pkg::*;

   localparam logic [3:0] ST_IDLE         = 4'd0;
   localparam logic [3:0] ST_FIRE_CHECK   = 4'd1;
   localparam logic [3:0] ST_SCAN         = 4'd2;
   localparam logic [3:0] ST_INSERT       = 4'd3;
   localparam logic [3:0] ST_DIV          = 4'd4;
   localparam logic [3:0] ST_CANCEL_CHECK = 4'd5;
   localparam logic [3:0] ST_CANCEL       = 4'd6;
   localparam logic [3:0] ST_COUNT        = 4'd7;
   localparam logic [3:0] ST_FINISH       = 4'd8;

   cfg_type    cfg;
   q_cmd_type  q_cmd;
   q_stat_type q_stat;

   logic [3:0]              state_ff, state_in;
   logic signed [POT_W-1:0] pot_ff, pot_in;
   logic [CNT_W-1:0]        pending_ff, pending_in;
   logic                    scan_fire_ff, scan_fire_in;   // scan feeds insert, else cancel
   logic                    fire_seen_ff, fire_seen_in;   // a timer expired this tick
   logic                    fire_hold_ff, fire_hold_in;
   logic [LEVEL_W-1:0]      level_ff, level_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POT_W-1:0] rsp_pot_ff, rsp_pot_in;
   logic [LEVEL_W-1:0]      rsp_level_ff, rsp_level_in;
   logic [QCNT_W-1:0]       rsp_queued_ff, rsp_queued_in;
   logic                    rsp_started_ff, rsp_started_in;

   // potential datapath
   logic [POT_W:0]          pot17;
   logic [POT_W:0]          thr17;
   logic                    above_thr;
   logic                    below_neg_thr;
   logic [POT_W-1:0]        react;
   logic [POT_W:0]          mag17;
   logic [POT_W-1:0]        mag;
   logic [POT_W:0]          pot_react17;
   logic [POT_W:0]          pot_cancel17;
   logic [THR_W-1:0]        excess;
   logic [DIVIDEND_W-1:0]   dividend;
   logic [POT_W+1:0]        pot_div18;

   // schedule time
   logic [TIMER_W-1:0]      delay;
   logic [TIMER_W:0]        later17;
   logic [TIMER_W-1:0]      later;
   logic [TIMER_W-1:0]      when;

   logic                    queue_full;
   logic                    rem_start;
   logic                    rem_done;
   logic [POT_W-1:0]        rem_value;
   logic                    out_free;
   logic [CNT_W+QCNT_W-1:0] pending_wide;

   sdq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sdq_timer_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (q_cmd),
      .stat  (q_stat)
   );

   sdq_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (dividend),
      .divisor   (mag),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign pot17         = {pot_ff[POT_W-1], pot_ff};
   assign thr17         = {2'b00, cfg.fire_threshold};
   assign above_thr     = $signed(pot17) > $signed(thr17);
   assign below_neg_thr = $signed(pot17) < -$signed(thr17);

   // a non-negative reaction acts as -1 so the firing loop always ends
   assign react = cfg.post_fire_reaction[POT_W-1] ? cfg.post_fire_reaction : '1;
   assign mag17 = (POT_W+1)'(0) - {react[POT_W-1], react};
   assign mag   = mag17[POT_W-1:0];

   // above threshold the potential is positive and adding the reaction cannot
   // drop below the signed range; below minus threshold adding it back is negative
   assign pot_react17  = pot17 + {react[POT_W-1], react};
   assign pot_cancel17 = pot17 + thr17;

   // full queue: the rest of the loop only lowers the potential, so the end
   // value is threshold + ((excess-1) mod mag) + 1 - mag
   assign excess    = pot_ff[THR_W-1:0] - cfg.fire_threshold;
   assign dividend  = excess - THR_W'(1);
   assign pot_div18 = {3'b000, cfg.fire_threshold} + {2'b00, rem_value}
                      + (POT_W+2)'(1) - {2'b00, mag};

   assign delay   = (cfg.travel_delay == '0) ? TIMER_W'(1) : cfg.travel_delay;
   assign later17 = {1'b0, q_stat.best_val} + {1'b0, cfg.fire_spacing};
   assign later   = later17[TIMER_W] ? '1 : later17[TIMER_W-1:0];
   assign when    = (pending_ff != '0 && later > delay) ? later : delay;

   assign queue_full   = (pending_ff == CNT_W'(QUEUE_SLOTS));
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign pending_wide = {{QCNT_W{1'b0}}, pending_ff};

   always_comb begin
      state_in       = state_ff;
      pot_in         = pot_ff;
      pending_in     = pending_ff;
      scan_fire_in   = scan_fire_ff;
      fire_seen_in   = fire_seen_ff;
      fire_hold_in   = fire_hold_ff;
      level_in       = level_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_pot_in     = rsp_pot_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_queued_in  = rsp_queued_ff;
      rsp_started_in = rsp_started_ff;
      rem_start      = 1'b0;
      q_cmd          = '0;
      req_ch.ready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               pot_in       = req_ch.potential_in;
               fire_seen_in = 1'b0;
               state_in     = ST_FIRE_CHECK;
            end
         end
         ST_FIRE_CHECK: begin
            if (above_thr) begin
               if (queue_full) begin
                  rem_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  scan_fire_in = 1'b1;
                  state_in     = ST_SCAN;
               end
            end else begin
               state_in = ST_CANCEL_CHECK;
            end
         end
         ST_SCAN: begin
            q_cmd.scan = 1'b1;
            if (q_stat.last) begin
               state_in = scan_fire_ff ? ST_INSERT : ST_CANCEL;
            end
         end
         ST_INSERT: begin
            q_cmd.write = 1'b1;
            q_cmd.widx  = q_stat.empty_idx;
            q_cmd.wval  = when;
            pending_in  = pending_ff + CNT_W'(1);
            pot_in      = pot_react17[POT_W-1:0];
            state_in    = ST_FIRE_CHECK;
         end
         ST_DIV: begin
            if (rem_done) begin
               pot_in   = pot_div18[POT_W-1:0];
               state_in = ST_CANCEL_CHECK;
            end
         end
         ST_CANCEL_CHECK: begin
            if (below_neg_thr && pending_ff != '0) begin
               scan_fire_in = 1'b0;
               state_in     = ST_SCAN;
            end else begin
               state_in = ST_COUNT;
            end
         end
         ST_CANCEL: begin
            // only a pulse still beyond the no-return time can be withdrawn
            if (q_stat.best_val > cfg.no_return_time) begin
               q_cmd.write = 1'b1;
               q_cmd.widx  = q_stat.best_idx;
               q_cmd.wval  = '0;
               pending_in  = pending_ff - CNT_W'(1);
               pot_in      = pot_cancel17[POT_W-1:0];
            end
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            q_cmd.count = 1'b1;
            if (q_stat.expired) begin
               fire_seen_in = 1'b1;
               if (pending_ff != '0) begin
                  pending_in = pending_ff - CNT_W'(1);
               end
            end
            if (q_stat.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               // expiries in one tick start one pulse; a new one restarts the hold
               rsp_started_in = fire_seen_ff;
               if (fire_seen_ff) begin
                  fire_hold_in = 1'b1;
                  level_in     = cfg.fire_level;
               end else if (fire_hold_ff) begin
                  fire_hold_in = 1'b0;
               end else begin
                  level_in = cfg.idle_level;
               end
               rsp_valid_in  = 1'b1;
               rsp_pot_in    = pot_ff;
               rsp_level_in  = fire_seen_ff ? cfg.fire_level
                               : (fire_hold_ff ? level_ff : cfg.idle_level);
               rsp_queued_in = pending_wide[QCNT_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.potential_out = rsp_pot_ff;
   assign rsp_ch.dac_level     = rsp_level_ff;
   assign rsp_ch.pulses_queued = rsp_queued_ff;
   assign rsp_ch.pulse_started = rsp_started_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         fire_seen_ff <= 1'b0;
         fire_hold_ff <= 1'b0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         scan_fire_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         fire_seen_ff <= fire_seen_in;
         fire_hold_ff <= fire_hold_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_fire_ff <= scan_fire_in;
      end
   end

   always_ff @(posedge clock) begin
      pot_ff         <= pot_in;
      rsp_pot_ff     <= rsp_pot_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_queued_ff  <= rsp_queued_in;
      rsp_started_ff <= rsp_started_in;
   end

endmodule

FILE: dv/sdq_checker.sv
`timescale 1ns / 1ps
// Checker for the spike delay queue: snoops APB writes and both item channels,
// predicts every result item and compares it field by field.
// Depends on sdq_pkg and sdq_if.
module sdq_checker (
   input  logic                           clock,
   input  logic                           reset,
   sdq_req_if                             req_ch,
   sdq_rsp_if                             rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [sdq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sdq_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             fail_count,
   output int                             outstanding,
   output int                             results_checked,
   output int                             pulses_seen
);
   import sdq_pkg::*;

   typedef struct packed {
      logic signed [POT_W-1:0] potential;
      logic [LEVEL_W-1:0]      dac;
      logic [QCNT_W-1:0]       queued;
      logic                    started;
   } tick_result_type;

   tick_result_type    tick_results_due[$];

   // shadow of the block's settings and pulse state
   cfg_type            live_cfg;
   logic [TIMER_W-1:0] pulse_slots [QUEUE_SLOTS];
   int unsigned        queued_count;
   bit                 fire_pending;
   bit                 hold_next;
   logic [LEVEL_W-1:0] dac_held;

   int errors  = 0;
   int checked = 0;
   int pulses  = 0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] result %0d: %s", $time, checked, msg);
      errors++;
   endtask

   function automatic int sat16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // largest timer, lowest slot on ties
   function automatic int latest_slot();
      int best;
      best = 0;
      for (int i = 1; i < QUEUE_SLOTS; i++)
         if (pulse_slots[i] > pulse_slots[best]) best = i;
      return best;
   endfunction

   function automatic tick_result_type step_axon(input logic signed [POT_W-1:0] pin);
      tick_result_type r;
      int              pot;
      int              thr;
      int              react;
      int              s;
      int unsigned     delay;
      int unsigned     when;
      int unsigned     later;
      bit              started;
      pot     = pin;
      thr     = live_cfg.fire_threshold;
      react   = $signed(live_cfg.post_fire_reaction);
      if (react >= 0) react = -1;
      delay   = (live_cfg.travel_delay != 0) ? live_cfg.travel_delay : 1;
      started = 1'b0;

      // schedule pulses while above threshold; drop when every slot is busy
      while (pot > thr) begin
         when = delay;
         if (queued_count > 0) begin
            later = pulse_slots[latest_slot()] + live_cfg.fire_spacing;
            if (later > 65535) later = 65535;
            if (later > delay) when = later;
         end
         for (int i = 0; i < QUEUE_SLOTS; i++) begin
            if (pulse_slots[i] == 0) begin
               pulse_slots[i] = when[TIMER_W-1:0];
               queued_count++;
               break;
            end
         end
         pot = sat16(pot + react);
      end

      // cancel the latest pulse while it is still beyond the no-return time
      if (pot < -thr && queued_count > 0) begin
         s = latest_slot();
         if (pulse_slots[s] > live_cfg.no_return_time) begin
            pulse_slots[s] = '0;
            queued_count--;
            pot = sat16(pot + thr);
         end
      end

      for (int i = 0; i < QUEUE_SLOTS; i++) begin
         if (pulse_slots[i] != 0) begin
            pulse_slots[i]--;
            if (pulse_slots[i] == 0) begin
               fire_pending = 1'b1;
               if (queued_count > 0) queued_count--;
            end
         end
      end

      if (fire_pending) begin
         fire_pending = 1'b0;
         hold_next    = 1'b1;
         dac_held     = live_cfg.fire_level;
         started      = 1'b1;
      end else if (hold_next) begin
         hold_next = 1'b0;
      end else begin
         dac_held = live_cfg.idle_level;
      end

      r.potential = pot[POT_W-1:0];
      r.dac       = dac_held;
      r.queued    = queued_count[QCNT_W-1:0];
      r.started   = started;
      return r;
   endfunction

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         live_cfg.fire_threshold     = RST_FIRE_THRESHOLD;
         live_cfg.post_fire_reaction = RST_POST_FIRE_REACTION;
         live_cfg.fire_spacing       = RST_FIRE_SPACING;
         live_cfg.travel_delay       = RST_TRAVEL_DELAY;
         live_cfg.no_return_time     = RST_NO_RETURN_TIME;
         live_cfg.fire_level         = RST_FIRE_LEVEL;
         live_cfg.idle_level         = RST_IDLE_LEVEL;
         for (int i = 0; i < QUEUE_SLOTS; i++) pulse_slots[i] = '0;
         queued_count = 0;
         fire_pending = 1'b0;
         hold_next    = 1'b0;
         dac_held     = '0;
         tick_results_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_FIRE_THRESHOLD:     live_cfg.fire_threshold     = pwdata[THR_W-1:0];
               REG_POST_FIRE_REACTION: live_cfg.post_fire_reaction = pwdata[POT_W-1:0];
               REG_FIRE_SPACING:       live_cfg.fire_spacing       = pwdata[TIMER_W-1:0];
               REG_TRAVEL_DELAY:       live_cfg.travel_delay       = pwdata[TIMER_W-1:0];
               REG_NO_RETURN_TIME:     live_cfg.no_return_time     = pwdata[TIMER_W-1:0];
               REG_FIRE_LEVEL:         live_cfg.fire_level         = pwdata[LEVEL_W-1:0];
               REG_IDLE_LEVEL:         live_cfg.idle_level         = pwdata[LEVEL_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            tick_results_due.push_back(step_axon(req_ch.potential_in));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (tick_results_due.size() == 0) begin
               report_mismatch("result item arrived with nothing expected");
            end else begin
               want = tick_results_due.pop_front();
               if (rsp_ch.potential_out !== want.potential)
                  report_mismatch($sformatf("potential_out got %0d, expected %0d",
                                            rsp_ch.potential_out, want.potential));
               if (rsp_ch.dac_level !== want.dac)
                  report_mismatch($sformatf("dac_level got %0d, expected %0d",
                                            rsp_ch.dac_level, want.dac));
               if (rsp_ch.pulses_queued !== want.queued)
                  report_mismatch($sformatf("pulses_queued got %0d, expected %0d",
                                            rsp_ch.pulses_queued, want.queued));
               if (rsp_ch.pulse_started !== want.started)
                  report_mismatch($sformatf("pulse_started got %0d, expected %0d",
                                            rsp_ch.pulse_started, want.started));
               if (want.started) pulses++;
               checked++;
            end
         end
      end
      fail_count      <= errors;
      outstanding     <= tick_results_due.size();
      results_checked <= checked;
      pulses_seen     <= pulses;
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the spike delay queue testbench: clock, reset, APB writes, item stimulus
// and the verdict. Depends on sdq_pkg, sdq_if, spike_delay_queue and sdq_checker.
module testbench;
   import sdq_pkg::*;

   // guard only; a correct run needs a small fraction of this
   localparam int CYCLE_LIMIT  = 1_500_000;
   // quiet cycles after the last result, well past the slowest item
   localparam int DRAIN_CYCLES = 150;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int outstanding;
   int results_checked;
   int pulses_seen;

   int cycle_count   = 0;
   int items_sent    = 0;
   int settings_used = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // what the stimulus aims around: current threshold and reaction size
   int cur_thr       = 256;
   int cur_react_mag = 256;

   sdq_req_if req_ch ();
   sdq_rsp_if rsp_ch ();

   spike_delay_queue u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   sdq_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .pulses_seen     (pulses_seen)
   );

   always #1 clock = ~clock;

   // receiver: ready is redrawn every cycle at the current stall rate
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // run guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL spike_delay_queue");
      $finish;
   end

   // APB write: setup cycle, then access cycle; pready is waited on anyway
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // all seven registers per setting; call only while drained
   task automatic apply_settings(input int thr, input int react, input int spacing,
                                 input int delay, input int no_return,
                                 input int fire, input int idle);
      csr_write(REG_FIRE_THRESHOLD,     32'(thr) & 32'h0000_7FFF);
      csr_write(REG_POST_FIRE_REACTION, 32'(react) & 32'h0000_FFFF);
      csr_write(REG_FIRE_SPACING,       32'(spacing) & 32'h0000_FFFF);
      csr_write(REG_TRAVEL_DELAY,       32'(delay) & 32'h0000_FFFF);
      csr_write(REG_NO_RETURN_TIME,     32'(no_return) & 32'h0000_FFFF);
      csr_write(REG_FIRE_LEVEL,         32'(fire) & 32'h0000_00FF);
      csr_write(REG_IDLE_LEVEL,         32'(idle) & 32'h0000_00FF);
      cur_thr       = thr & 32'h7FFF;
      // a non-negative reaction acts as -1 in the block
      cur_react_mag = (react < 0) ? -react : 1;
      settings_used++;
   endtask

   // Idle rates by progress: sender 35 / receiver 56 first, then swapped,
   // then a stretch where neither side stalls.
   task automatic set_idle_mode();
      if (items_sent < 530) begin
         send_idle_pct <= 35;
         recv_idle_pct <= 56;
      end else if (items_sent < 1060) begin
         send_idle_pct <= 56;
         recv_idle_pct <= 35;
      end else begin
         send_idle_pct <= 0;
         recv_idle_pct <= 0;
      end
   endtask

   // Send one potential. valid is left high after acceptance so that a
   // back-to-back item never lowers and raises it in the same step.
   task automatic send_potential(input logic signed [POT_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.potential_in <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // Pause the sender until every expected result has been checked.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Mostly potentials near the thresholds, so pulses get scheduled,
   // cancelled and left to count down; some full-range and extreme values.
   function automatic logic signed [POT_W-1:0] pick_potential();
      int v;
      int sel;
      sel = $urandom_range(99);
      if (sel < 30)
         v = cur_thr + int'($urandom_range(1, 3 * cur_react_mag));
      else if (sel < 50)
         v = -cur_thr - int'($urandom_range(1, 2 * cur_react_mag + 1));
      else if (sel < 85)
         v = int'($urandom_range(0, 2 * cur_thr)) - cur_thr;
      else if (sel < 95)
         v = int'($urandom_range(65535)) - 32768;
      else
         v = ($urandom_range(1) != 0) ? 32767 : -32768;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[POT_W-1:0];
   endfunction

   // Random items under the current setting, with an occasional full pause.
   task automatic run_phase(input int count);
      set_idle_mode();
      for (int k = 0; k < count; k++) begin
         send_potential(pick_potential());
         if ($urandom_range(79) == 0) drain_results();
      end
      drain_results();
   endtask

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.potential_in <= '0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings: full queue with dropped pulses, cancel at
      // the most negative input, threshold edges on both sides.
      set_idle_mode();
      send_potential(16'sh7FFF);
      send_potential(-16'sh8000);
      send_potential(16'sd257);
      send_potential(16'sd256);
      send_potential(-16'sd256);
      send_potential(-16'sd257);
      drain_results();

      // Directed, short delay and spacing of one: pulses expire on
      // consecutive ticks, so a new request lands during the hold.
      apply_settings(256, -256, 1, 3, 1, 200, 30);
      send_potential(16'sh7FFF);
      send_potential(-16'sh8000);
      for (int k = 0; k < 7; k++) send_potential(16'sd0);
      send_potential(16'sd257);
      send_potential(-16'sd257);
      send_potential(16'sd0);
      send_potential(16'sh5555);
      send_potential(16'shAAAA);
      send_potential(16'sd0);
      send_potential(16'sd1);
      send_potential(-16'sd1);
      drain_results();

      // reset values restored by writes
      apply_settings(int'(RST_FIRE_THRESHOLD), -256, int'(RST_FIRE_SPACING),
                     int'(RST_TRAVEL_DELAY), int'(RST_NO_RETURN_TIME),
                     int'(RST_FIRE_LEVEL), int'(RST_IDLE_LEVEL));
      run_phase(140);
      // low extremes: zero threshold and spacing, so many timers expire together
      apply_settings(0, -32768, 0, 1, 0, 0, 255);
      run_phase(140);
      // high extremes: nothing can fire; only -32768 lies below minus threshold
      apply_settings(32767, -1, 65535, 65535, 65535, 255, 0);
      run_phase(40);
      // zero reaction acts as -1 and zero travel delay as one
      apply_settings(300, 0, 2, 0, 0, 99, 1);
      run_phase(140);
      // positive reaction also acts as -1
      apply_settings(64, 32767, 0, 2, 1, 170, 85);
      run_phase(140);
      // huge spacing: the schedule sum saturates, the cancel path gets busy
      apply_settings(256, -256, 65500, 5, 10, 128, 64);
      run_phase(140);

      for (int p = 0; p < 6; p++) begin
         apply_settings(int'($urandom_range(1500)), -int'($urandom_range(1, 900)),
                        int'($urandom_range(25)),
                        ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 50)),
                        int'($urandom_range(30)), int'($urandom_range(255)),
                        int'($urandom_range(255)));
         run_phase(140);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d potentials under %0d register settings, %0d results compared.",
               items_sent, settings_used, results_checked);
      $display("%0d pulses started; stall rates varied on both channels.", pulses_seen);
      if (fail_count == 0)
         $display("PASS spike_delay_queue");
      else
         $display("FAIL spike_delay_queue");
      $finish;
   end

endmodule
